// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the job scheduler block.
// Depends on: nothing; the using module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define JSSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("job scheduler check failed");

// Check a property at every clock edge, reset included.
`define JSSE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("job scheduler check failed");

`endif

// ===== src/jsse_pkg.sv =====
// Shared types, constants and helpers for the job scheduler segment engine.
// Depends on: nothing.
`default_nettype none

package jsse_pkg;

  localparam int MAX_JOBS = 64;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int TIME_W   = 23;
  localparam int TOT_W    = 16 + IDX_W;
  localparam int DRAW_W   = 32;
  localparam int DCNT_W   = $clog2(DRAW_W + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Policy codes
  localparam logic [2:0] POL_FIFO = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_STCF = 3'd2;
  localparam logic [2:0] POL_RR   = 3'd3;
  localparam logic [2:0] POL_LOT  = 3'd4;

  // Register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SLICE  = 1'b1;

  // Job selection sources
  localparam logic [2:0] SEL_FIFO  = 3'd0;
  localparam logic [2:0] SEL_SJ    = 3'd1;
  localparam logic [2:0] SEL_RR    = 3'd2;
  localparam logic [2:0] SEL_FIRST = 3'd3;
  localparam logic [2:0] SEL_LOT   = 3'd4;

  // One job table row
  typedef struct packed {
    logic [15:0]       arr;
    logic [15:0]       len;
    logic [15:0]       tk;
    logic [15:0]       rem;
    logic [TIME_W-1:0] frun;
  } row_t;

  // Controller to datapath
  typedef struct packed {
    logic       add;
    logic       clear;
    logic       step;
    logic       scan_start;
    logic       scan_lot;
    logic       jump;
    logic       select;
    logic [2:0] sel;
    logic       row_read;
    logic       exec;
    logic       seg_first;
    logic       div_start;
    logic       emit;
    logic       emit_all;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] policy;
    logic       scan_done;
    logic       any_unf;
    logic       ready_found;
    logic       na_found;
    logic       tot_zero;
    logic       sj_ne_run;
    logic       div_idle;
    logic       run_done;
  } sts_t;

  // Map unknown policy codes onto FIFO
  function automatic logic [2:0] norm_policy(input logic [2:0] p);
    logic [2:0] r;
    r = (p > POL_LOT) ? POL_FIFO : p;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/jsse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on: nothing.
`default_nettype none

module jsse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/jsse_ctrl.sv =====
// Controller state machine: sequences table scans, time jumps, the remainder
// unit, the row update and the result. Depends on: jsse_pkg.
`default_nettype none

module jsse_ctrl import jsse_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [1:0] req_type_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o,
  output logic            busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_LSCAN = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_EXE   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       jumped_q, jumped_d;
  logic       cont_q, cont_d;
  logic       first_q, first_d;
  logic       all_q, all_d;

  assign busy = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    jumped_d = jumped_q;
    cont_d   = cont_q;
    first_d  = first_q;
    all_d    = all_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_type_i)
            REQ_ADD:   cmd_o.add = 1'b1;
            REQ_CLEAR: cmd_o.clear = 1'b1;
            REQ_STEP: begin
              cmd_o.step       = 1'b1;
              cmd_o.scan_start = 1'b1;
              jumped_d         = 1'b0;
              cont_d           = 1'b0;
              first_d          = 1'b1;
              all_d            = 1'b0;
              state_d          = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          if (cont_q) begin
            // preemption check after an arrival
            state_d = sts_i.sj_ne_run ? S_EMIT : S_RD;
          end else if (!sts_i.any_unf) begin
            all_d   = 1'b1;
            state_d = S_EMIT;
          end else begin
            case (sts_i.policy)
              POL_SJF, POL_STCF: begin
                if (!sts_i.ready_found && !jumped_q) begin
                  cmd_o.jump       = 1'b1;
                  cmd_o.scan_start = 1'b1;
                  jumped_d         = 1'b1;
                end else begin
                  cmd_o.select = 1'b1;
                  cmd_o.sel    = SEL_SJ;
                  state_d      = S_RD;
                end
              end
              POL_RR: begin
                if (jumped_q) begin
                  cmd_o.select = 1'b1;
                  cmd_o.sel    = SEL_FIRST;
                  state_d      = S_RD;
                end else if (sts_i.ready_found) begin
                  cmd_o.select = 1'b1;
                  cmd_o.sel    = SEL_RR;
                  state_d      = S_RD;
                end else begin
                  cmd_o.jump       = 1'b1;
                  cmd_o.scan_start = 1'b1;
                  jumped_d         = 1'b1;
                end
              end
              POL_LOT: begin
                if (sts_i.tot_zero && sts_i.na_found) begin
                  cmd_o.jump       = 1'b1;
                  cmd_o.scan_start = 1'b1;
                end else if (!sts_i.tot_zero) begin
                  cmd_o.div_start = 1'b1;
                  state_d         = S_DIV;
                end else begin
                  cmd_o.select = 1'b1;
                  cmd_o.sel    = SEL_FIRST;
                  state_d      = S_RD;
                end
              end
              default: begin
                cmd_o.select = 1'b1;
                cmd_o.sel    = SEL_FIFO;
                state_d      = S_RD;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_idle) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_lot   = 1'b1;
          state_d          = S_LSCAN;
        end
      end
      S_LSCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.select = 1'b1;
          cmd_o.sel    = SEL_LOT;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        cmd_o.row_read = 1'b1;
        state_d        = S_EXE;
      end
      S_EXE: begin
        cmd_o.exec      = 1'b1;
        cmd_o.seg_first = first_q;
        first_d         = 1'b0;
        if (sts_i.policy == POL_STCF && !sts_i.run_done) begin
          cmd_o.scan_start = 1'b1;
          cont_d           = 1'b1;
          state_d          = S_SCAN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_all = all_q;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      jumped_q <= 1'b0;
      cont_q   <= 1'b0;
      first_q  <= 1'b0;
      all_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      jumped_q <= jumped_d;
      cont_q   <= cont_d;
      first_q  <= first_d;
      all_q    <= all_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/jsse_dp.sv =====
// Datapath: configuration, job table RAM, flags, time, scan accumulators,
// remainder unit, row update and result registers. Depends on: jsse_pkg, jsse_ram.
`default_nettype none

module jsse_dp import jsse_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_addr_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic [15:0]       arrival_i,
  input  wire logic [15:0]       length_i,
  input  wire logic [15:0]       tickets_i,
  input  wire logic [DRAW_W-1:0] random_draw_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  output logic                   result_valid_o,
  output logic [TIME_W-1:0]      seg_start_o,
  output logic [5:0]             job_index_o,
  output logic [15:0]            job_arrival_o,
  output logic [15:0]            ran_ticks_o,
  output logic                   job_completed_o,
  output logic [TIME_W-1:0]      response_time_o,
  output logic [TIME_W-1:0]      turnaround_time_o,
  output logic [TIME_W-1:0]      wait_time_o,
  output logic                   all_finished_o
);

  // Configuration and table state
  logic [2:0]        policy_q;
  logic [15:0]       slice_q;
  logic [2:0]        pol;
  logic [15:0]       slice_eff;
  logic [CNT_W-1:0]  count_q;
  logic [TIME_W-1:0] t_q;
  logic [IDX_W-1:0]  rot_pos_q;
  logic              rot_vld_q;
  logic [MAX_JOBS-1:0] started_q, fin_q;
  logic [DRAW_W-1:0] draw_q;
  logic [IDX_W-1:0]  run_idx_q;

  // RAM ports
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  row_t             ram_wdata, row;

  // Scan state and accumulators
  logic             sc_act_q, sc_vld_q, lot_pass_q;
  logic [CNT_W-1:0] sc_addr_q;
  logic [IDX_W-1:0] sc_k_q;
  logic             sc_issue, sc_done;
  logic             any_unf_q;
  logic             fifo_found_q, fr_found_q, rr_found_q, na_found_q, sj_found_q, lot_found_q;
  logic [IDX_W-1:0] fifo_idx_q, fr_idx_q, rr_idx_q, sj_idx_q, lot_idx_q;
  logic [15:0]      na_q, sj_rem_q, sj_arr_q;
  logic [TOT_W-1:0] tot_q, acc_q;

  // Remainder unit
  logic [DCNT_W-1:0] dv_cnt_q;
  logic [TOT_W-1:0]  dv_rem_q;
  logic [DRAW_W-1:0] dv_num_q;
  logic [TOT_W:0]    dv_r2;
  logic [TOT_W-1:0]  dv_next;

  // Emit operands
  logic [15:0]       e_arr_q, e_len_q, ran_acc_q;
  logic [TIME_W-1:0] e_frun_q, seg_start_q;
  logic              e_done_q;

  assign pol       = norm_policy(policy_q);
  assign slice_eff = (slice_q == 16'd0) ? 16'd1 : slice_q;
  assign row       = ram_rdata_w;

  row_t ram_rdata_w;

  jsse_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (MAX_JOBS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_w)
  );

  // Scan address issue
  assign sc_issue = sc_act_q && (sc_addr_q < count_q);
  assign sc_done  = sc_act_q && !sc_issue && !sc_vld_q;

  // Per-entry evaluation of the row coming out of the RAM
  logic [TIME_W-1:0] e_arr23;
  logic              e_unf, e_rdy, e_late, sj_better;
  logic [IDX_W-1:0]  from_idx;
  logic [TOT_W-1:0]  acc_sum;

  always_comb begin
    e_arr23   = {{(TIME_W-16){1'b0}}, row.arr};
    e_unf     = !fin_q[sc_k_q];
    e_rdy     = e_unf && (e_arr23 <= t_q);
    e_late    = e_unf && (e_arr23 > t_q);
    sj_better = !sj_found_q || (row.rem < sj_rem_q) ||
                ((row.rem == sj_rem_q) && (row.arr < sj_arr_q));
    from_idx  = (rot_vld_q && ({1'b0, rot_pos_q} < count_q)) ? rot_pos_q : '0;
    acc_sum   = acc_q + {{(TOT_W-16){1'b0}}, row.tk};
  end

  // Run length and row update for the selected job
  logic [TIME_W-1:0] ex_arr23, ex_start, ex_t_new, ex_frun;
  logic [15:0]       ex_ran, ex_rem_new, na_gap, slice_min;
  logic [TIME_W:0]   ex_sum;

  always_comb begin
    ex_arr23  = {{(TIME_W-16){1'b0}}, row.arr};
    ex_start  = (pol == POL_FIFO && t_q < ex_arr23) ? ex_arr23 : t_q;
    na_gap    = 16'(na_q - t_q[15:0]);
    slice_min = (slice_eff < row.rem) ? slice_eff : row.rem;
    case (pol)
      POL_STCF:        ex_ran = (na_found_q && na_gap < row.rem) ? na_gap : row.rem;
      POL_RR, POL_LOT: ex_ran = slice_min;
      default:         ex_ran = row.rem;
    endcase
    ex_rem_new = row.rem - ex_ran;
    ex_sum     = {1'b0, ex_start} + {{(TIME_W-15){1'b0}}, ex_ran};
    ex_t_new   = (ex_sum > {1'b0, TIME_MAX}) ? TIME_MAX : ex_sum[TIME_W-1:0];
    ex_frun    = started_q[run_idx_q] ? row.frun : ex_start;
  end

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = run_idx_q;
    ram_wdata = row;
    if (cmd_i.add && count_q < CNT_W'(MAX_JOBS)) begin
      ram_we         = 1'b1;
      ram_waddr      = count_q[IDX_W-1:0];
      ram_wdata.arr  = arrival_i;
      ram_wdata.len  = (length_i == 16'd0) ? 16'd1 : length_i;
      ram_wdata.rem  = (length_i == 16'd0) ? 16'd1 : length_i;
      ram_wdata.tk   = tickets_i;
      ram_wdata.frun = '0;
    end else if (cmd_i.exec) begin
      ram_we         = 1'b1;
      ram_wdata.rem  = ex_rem_new;
      ram_wdata.frun = ex_frun;
    end
    ram_re    = sc_issue || cmd_i.row_read;
    ram_raddr = sc_issue ? sc_addr_q[IDX_W-1:0] : run_idx_q;
  end

  // Remainder step: shift in one dividend bit, subtract when it fits
  always_comb begin
    dv_r2   = {dv_rem_q, dv_num_q[DRAW_W-1]};
    dv_next = (dv_r2 >= {1'b0, tot_q}) ? TOT_W'(dv_r2 - {1'b0, tot_q})
                                       : dv_r2[TOT_W-1:0];
  end

  // Status
  always_comb begin
    sts_o.policy      = pol;
    sts_o.scan_done   = sc_done;
    sts_o.any_unf     = any_unf_q;
    sts_o.ready_found = fr_found_q;
    sts_o.na_found    = na_found_q;
    sts_o.tot_zero    = (tot_q == '0);
    sts_o.sj_ne_run   = (sj_idx_q != run_idx_q);
    sts_o.div_idle    = (dv_cnt_q == '0);
    sts_o.run_done    = (ex_rem_new == 16'd0);
  end

  // Completion figures
  logic [TIME_W-1:0] c_arr23, c_len23, c_resp, c_turn, c_wait;

  always_comb begin
    c_arr23 = {{(TIME_W-16){1'b0}}, e_arr_q};
    c_len23 = {{(TIME_W-16){1'b0}}, e_len_q};
    c_resp  = e_frun_q - c_arr23;
    c_turn  = t_q - c_arr23;
    c_wait  = (c_turn >= c_len23) ? (c_turn - c_len23) : '0;
  end

  // Configuration, table state and scheduling time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_FIFO;
      slice_q   <= 16'd1;
      count_q   <= '0;
      t_q       <= '0;
      rot_pos_q <= '0;
      rot_vld_q <= 1'b0;
      started_q <= '0;
      fin_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_POLICY: policy_q <= cfg_wdata_i[2:0];
          REG_SLICE:  slice_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        count_q   <= '0;
        t_q       <= '0;
        rot_pos_q <= '0;
        rot_vld_q <= 1'b0;
        started_q <= '0;
        fin_q     <= '0;
      end else if (cmd_i.add && count_q < CNT_W'(MAX_JOBS)) begin
        count_q                       <= count_q + 1'b1;
        started_q[count_q[IDX_W-1:0]] <= 1'b0;
        fin_q[count_q[IDX_W-1:0]]     <= 1'b0;
      end
      if (cmd_i.jump) begin
        t_q <= {{(TIME_W-16){1'b0}}, na_q};
      end
      if (cmd_i.exec) begin
        t_q                  <= ex_t_new;
        started_q[run_idx_q] <= 1'b1;
        if (ex_rem_new == 16'd0) begin
          fin_q[run_idx_q] <= 1'b1;
        end
        if (pol == POL_RR) begin
          rot_vld_q <= 1'b1;
          rot_pos_q <= ({1'b0, run_idx_q} + 1'b1 == count_q) ? '0
                                                            : IDX_W'(run_idx_q + 1'b1);
        end
      end
    end
  end

  // Table scan and its accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_act_q     <= 1'b0;
      sc_vld_q     <= 1'b0;
      lot_pass_q   <= 1'b0;
      sc_addr_q    <= '0;
      sc_k_q       <= '0;
      any_unf_q    <= 1'b0;
      fifo_found_q <= 1'b0;
      fr_found_q   <= 1'b0;
      rr_found_q   <= 1'b0;
      na_found_q   <= 1'b0;
      sj_found_q   <= 1'b0;
      lot_found_q  <= 1'b0;
      fifo_idx_q   <= '0;
      fr_idx_q     <= '0;
      rr_idx_q     <= '0;
      sj_idx_q     <= '0;
      lot_idx_q    <= '0;
      na_q         <= '0;
      sj_rem_q     <= '0;
      sj_arr_q     <= '0;
      tot_q        <= '0;
      acc_q        <= '0;
    end else if (cmd_i.scan_start) begin
      sc_act_q     <= 1'b1;
      sc_vld_q     <= 1'b0;
      lot_pass_q   <= cmd_i.scan_lot;
      sc_addr_q    <= '0;
      any_unf_q    <= 1'b0;
      fifo_found_q <= 1'b0;
      fr_found_q   <= 1'b0;
      rr_found_q   <= 1'b0;
      na_found_q   <= 1'b0;
      sj_found_q   <= 1'b0;
      lot_found_q  <= 1'b0;
      acc_q        <= '0;
      if (!cmd_i.scan_lot) begin
        tot_q <= '0;
      end
    end else begin
      // advance the read address
      sc_vld_q <= sc_issue;
      if (sc_issue) begin
        sc_k_q    <= sc_addr_q[IDX_W-1:0];
        sc_addr_q <= sc_addr_q + 1'b1;
      end
      if (sc_done) begin
        sc_act_q <= 1'b0;
      end
      // fold in the entry read last cycle
      if (sc_vld_q && !lot_pass_q) begin
        if (e_unf) begin
          any_unf_q <= 1'b1;
        end
        if (e_unf && !fifo_found_q) begin
          fifo_found_q <= 1'b1;
          fifo_idx_q   <= sc_k_q;
        end
        if (e_rdy && !fr_found_q) begin
          fr_found_q <= 1'b1;
          fr_idx_q   <= sc_k_q;
        end
        if (e_rdy && !rr_found_q && sc_k_q >= from_idx) begin
          rr_found_q <= 1'b1;
          rr_idx_q   <= sc_k_q;
        end
        if (e_late && (!na_found_q || row.arr < na_q)) begin
          na_found_q <= 1'b1;
          na_q       <= row.arr;
        end
        if (e_rdy) begin
          tot_q <= tot_q + {{(TOT_W-16){1'b0}}, row.tk};
        end
        if (e_rdy && sj_better) begin
          sj_found_q <= 1'b1;
          sj_idx_q   <= sc_k_q;
          sj_rem_q   <= row.rem;
          sj_arr_q   <= row.arr;
        end
      end
      if (sc_vld_q && lot_pass_q && e_rdy && !lot_found_q) begin
        acc_q <= acc_sum;
        if (acc_sum > dv_rem_q) begin
          lot_found_q <= 1'b1;
          lot_idx_q   <= sc_k_q;
        end
      end
    end
  end

  // Remainder unit, selection and segment bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_cnt_q    <= '0;
      dv_rem_q    <= '0;
      dv_num_q    <= '0;
      draw_q      <= '0;
      run_idx_q   <= '0;
      e_arr_q     <= '0;
      e_len_q     <= '0;
      e_frun_q    <= '0;
      e_done_q    <= 1'b0;
      seg_start_q <= '0;
      ran_acc_q   <= '0;
    end else begin
      if (cmd_i.step) begin
        draw_q <= random_draw_i;
      end
      if (cmd_i.div_start) begin
        dv_cnt_q <= DCNT_W'(DRAW_W);
        dv_rem_q <= '0;
        dv_num_q <= draw_q;
      end else if (dv_cnt_q != '0) begin
        dv_cnt_q <= dv_cnt_q - 1'b1;
        dv_rem_q <= dv_next;
        dv_num_q <= {dv_num_q[DRAW_W-2:0], 1'b0};
      end
      if (cmd_i.select) begin
        case (cmd_i.sel)
          SEL_SJ:    run_idx_q <= sj_idx_q;
          SEL_RR:    run_idx_q <= rr_found_q ? rr_idx_q : fr_idx_q;
          SEL_FIRST: run_idx_q <= fr_idx_q;
          SEL_LOT:   run_idx_q <= lot_found_q ? lot_idx_q : fr_idx_q;
          default:   run_idx_q <= fifo_idx_q;
        endcase
      end
      if (cmd_i.exec) begin
        e_arr_q  <= row.arr;
        e_len_q  <= row.len;
        e_frun_q <= ex_frun;
        e_done_q <= (ex_rem_new == 16'd0);
        if (cmd_i.seg_first) begin
          seg_start_q <= ex_start;
          ran_acc_q   <= ex_ran;
        end else begin
          ran_acc_q <= ran_acc_q + ex_ran;
        end
      end
    end
  end

  // Result registers: each result is held until the next one is shown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o    <= 1'b0;
      seg_start_o       <= '0;
      job_index_o       <= '0;
      job_arrival_o     <= '0;
      ran_ticks_o       <= '0;
      job_completed_o   <= 1'b0;
      response_time_o   <= '0;
      turnaround_time_o <= '0;
      wait_time_o       <= '0;
      all_finished_o    <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
      if (cmd_i.emit) begin
        if (cmd_i.emit_all) begin
          seg_start_o       <= '0;
          job_index_o       <= '0;
          job_arrival_o     <= '0;
          ran_ticks_o       <= '0;
          job_completed_o   <= 1'b0;
          response_time_o   <= '0;
          turnaround_time_o <= '0;
          wait_time_o       <= '0;
          all_finished_o    <= 1'b1;
        end else begin
          seg_start_o       <= seg_start_q;
          job_index_o       <= 6'(run_idx_q);
          job_arrival_o     <= e_arr_q;
          ran_ticks_o       <= ran_acc_q;
          job_completed_o   <= e_done_q;
          response_time_o   <= e_done_q ? c_resp : '0;
          turnaround_time_o <= e_done_q ? c_turn : '0;
          wait_time_o       <= e_done_q ? c_wait : '0;
          all_finished_o    <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/job_scheduler_segment_engine.sv =====
// Top level of the job scheduler segment engine: controller plus datapath.
// Depends on: jsse_pkg, jsse_ctrl, jsse_dp (and through it jsse_ram).
//
// Add and clear requests are taken at once and do not raise busy. A step request
// runs passes over the loaded jobs, each pass reading every row through the
// single read port of the job table RAM: one pass, a second one after a jump to
// the next arrival, and for lottery a remainder step plus one more pass; the row
// read, the row update and the result follow. Shortest time to completion
// rescans the table at every arrival inside its segment, so such a step can take
// one pass per arrival it crosses. The result is shown for a single cycle with
// result_valid_o and cannot be held off; busy stays high until that cycle.
`default_nettype none

module job_scheduler_segment_engine import jsse_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_addr_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [15:0]       arrival_i,
  input  wire logic [15:0]       length_i,
  input  wire logic [15:0]       tickets_i,
  input  wire logic [DRAW_W-1:0] random_draw_i,
  output logic                   result_valid_o,
  output logic [TIME_W-1:0]      seg_start_o,
  output logic [5:0]             job_index_o,
  output logic [15:0]            job_arrival_o,
  output logic [15:0]            ran_ticks_o,
  output logic                   job_completed_o,
  output logic [TIME_W-1:0]      response_time_o,
  output logic [TIME_W-1:0]      turnaround_time_o,
  output logic [TIME_W-1:0]      wait_time_o,
  output logic                   all_finished_o
);

  cmd_t cmd;
  sts_t sts;

  jsse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  jsse_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .arrival_i         (arrival_i),
    .length_i          (length_i),
    .tickets_i         (tickets_i),
    .random_draw_i     (random_draw_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .result_valid_o    (result_valid_o),
    .seg_start_o       (seg_start_o),
    .job_index_o       (job_index_o),
    .job_arrival_o     (job_arrival_o),
    .ran_ticks_o       (ran_ticks_o),
    .job_completed_o   (job_completed_o),
    .response_time_o   (response_time_o),
    .turnaround_time_o (turnaround_time_o),
    .wait_time_o       (wait_time_o),
    .all_finished_o    (all_finished_o)
  );

endmodule

`default_nettype wire

// ===== src/jsse_checker.sv =====
// Port-level checks for the job scheduler segment engine, bound to the top.
// Depends on: jsse_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module jsse_checker import jsse_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] req_type_i,
  input wire logic       result_valid_o,
  input wire logic       all_finished_o,
  input wire logic [15:0] ran_ticks_o
);

  // a result only closes a step that was in flight
  `JSSE_ASSERT(a_result_after_busy, result_valid_o |-> $past(busy))
  // a step request keeps the block busy
  `JSSE_ASSERT(a_step_goes_busy, (start && !busy && req_type_i == REQ_STEP) |=> busy)
  // add, clear and unknown requests finish at once
  `JSSE_ASSERT(a_other_no_busy, (start && !busy && req_type_i != REQ_STEP) |=> !busy)
  // drained table reports no segment
  `JSSE_ASSERT(a_drained_empty, (result_valid_o && all_finished_o) |-> ran_ticks_o == 16'd0)
  // nothing shown while in reset
  `JSSE_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!result_valid_o && !busy))

endmodule

bind job_scheduler_segment_engine jsse_checker u_jsse_checker (.*);

`default_nettype wire
